// File: design/assert_macros.svh
// Assertion macros used by the checker module of the project
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted
`define STC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");

// Clocked assertion that is also checked during reset
`define STC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("%m: assertion failed");

`endif

// File: design/stc_pkg.sv
// Types and constants for the shared tag cluster sizes block
package stc_pkg;

  // Default sizes of the label and tag stores
  localparam int MAX_PEOPLE_DEF = 64;
  localparam int NUM_TAGS_DEF   = 1024;

  // Fixed field widths
  localparam int PERSON_W = 6;
  localparam int HOBBY_W  = 10;
  localparam int COUNT_W  = 7;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_NUM_PEOPLE = 1'b0;
  localparam logic [COUNT_W-1:0] NUM_PEOPLE_RST = 7'd64;

  // Request codes
  localparam logic REQ_MEMBER = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [PERSON_W-1:0] person;
    logic [HOBBY_W-1:0]  hobby;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] cluster_count;
    logic [COUNT_W-1:0] grp_size;
    logic               last;
  } out_item_t;

endpackage

// File: design/stc_cfg.sv
// Configuration register file: people-in-use count and its clamped value
module stc_cfg #(
  parameter int MAX_PEOPLE = stc_pkg::MAX_PEOPLE_DEF,
  localparam int NW = $clog2(MAX_PEOPLE + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [stc_pkg::PADDR_W-1:0]  paddr_i,
  input  logic [stc_pkg::PDATA_W-1:0]  pwdata_i,
  output logic [stc_pkg::PDATA_W-1:0]  prdata_o,
  output logic                         pready_o,
  output logic [NW-1:0]                n_eff_o
);
  import stc_pkg::*;

  logic [COUNT_W-1:0] num_people_q;
  logic               reg_hit;

  // Word decode; byte offset bits are ignored
  assign reg_hit = (paddr_i[PADDR_W-1:2] == REG_NUM_PEOPLE);

  // Register write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_people_q <= NUM_PEOPLE_RST;
    end else if (psel_i && penable_i && pwrite_i && reg_hit) begin
      num_people_q <= pwdata_i[COUNT_W-1:0];
    end
  end

  assign pready_o = 1'b1;
  assign prdata_o = reg_hit ? PDATA_W'(num_people_q) : '0;

  // Zero acts as one, anything above the store size acts as the store size
  always_comb begin
    if (num_people_q == '0) begin
      n_eff_o = NW'(1);
    end else if (int'(num_people_q) > MAX_PEOPLE) begin
      n_eff_o = NW'(MAX_PEOPLE);
    end else begin
      n_eff_o = NW'(num_people_q);
    end
  end

endmodule

// File: design/shared_tag_cluster_sizes.sv
// Top level: quick-find clustering of people by shared hobby tags
//
//   channel   dir   handshake             payload
//   in        in    in_valid_i/in_stall_o  stc_pkg::in_item_t
//   out       out   out_valid_o/out_stall_i stc_pkg::out_item_t
//   cfg       in    APB psel/penable/pready paddr, pwdata, prdata
//
// Membership item: an ignored one is dropped in S_IDLE; an unseen or stale tag
// passes S_M_TAG and S_M_LA; matching labels end in S_M_CMP; a merge adds the
// relabel sweep, which walks the label memory one entry per cycle, and S_M_DRN.
// Report item: each person in use is counted by label, each label's count goes
// into the size histogram, then sizes are checked and each result is shown.
// After reset a clearing pass over every entry sets up the memories; no item
// is taken meanwhile, configuration writes are.
// in_stall_o is high while an item is in work; a stalled result holds.
module shared_tag_cluster_sizes #(
  parameter int MAX_PEOPLE = stc_pkg::MAX_PEOPLE_DEF,
  parameter int NUM_TAGS   = stc_pkg::NUM_TAGS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  stc_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output stc_pkg::out_item_t           out_item_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [stc_pkg::PADDR_W-1:0]  paddr,
  input  logic [stc_pkg::PDATA_W-1:0]  pwdata,
  output logic [stc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import stc_pkg::*;

  localparam int LW       = $clog2(MAX_PEOPLE);
  localparam int NW       = $clog2(MAX_PEOPLE + 1);
  localparam int TW       = $clog2(NUM_TAGS);
  localparam int INIT_LEN = (MAX_PEOPLE + 1 > NUM_TAGS) ? MAX_PEOPLE + 1 : NUM_TAGS;
  localparam int IW       = $clog2(INIT_LEN);

  typedef struct packed {
    logic                seen;
    logic [PERSON_W-1:0] member;
  } tag_ent_t;

  typedef enum logic [16:0] {
    S_INIT   = 17'd1 << 0,
    S_IDLE   = 17'd1 << 1,
    S_M_TAG  = 17'd1 << 2,
    S_M_LA   = 17'd1 << 3,
    S_M_LB   = 17'd1 << 4,
    S_M_CMP  = 17'd1 << 5,
    S_M_SWP  = 17'd1 << 6,
    S_M_DRN  = 17'd1 << 7,
    S_R_LRD  = 17'd1 << 8,
    S_R_CRD  = 17'd1 << 9,
    S_R_CWR  = 17'd1 << 10,
    S_R_HRD  = 17'd1 << 11,
    S_R_HCHK = 17'd1 << 12,
    S_R_HWR  = 17'd1 << 13,
    S_R_ERD  = 17'd1 << 14,
    S_R_ECHK = 17'd1 << 15,
    S_R_OUT  = 17'd1 << 16
  } state_e;

  // Effective people count from the register file
  logic [NW-1:0] n_eff;

  stc_cfg #(
    .MAX_PEOPLE (MAX_PEOPLE)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .n_eff_o   (n_eff)
  );

  // Control registers
  state_e        state_q, state_d;
  logic [IW-1:0] init_q, init_d;
  logic [NW-1:0] idx_q, idx_d;
  logic [NW-1:0] k_q, k_d;
  logic [NW-1:0] emit_q, emit_d;
  logic [NW-1:0] rem_q, rem_d;
  logic          pend_q, pend_d;
  logic          out_valid_q, out_valid_d;

  // Datapath registers
  logic [PERSON_W-1:0] person_q, person_d;
  logic [TW-1:0]       hobby_q, hobby_d;
  logic [LW-1:0]       la_q, la_d;
  logic [LW-1:0]       from_q, from_d;
  logic [LW-1:0]       to_q, to_d;
  logic [LW-1:0]       pidx_q, pidx_d;
  logic [LW-1:0]       lab_q, lab_d;
  logic [NW-1:0]       val_q, val_d;
  out_item_t           out_q, out_d;

  // Memory ports
  logic [LW-1:0] lbl_mem [MAX_PEOPLE];
  logic          lbl_we;
  logic [LW-1:0] lbl_wa, lbl_wd, lbl_ra, lbl_rd_q;

  tag_ent_t      tag_mem [NUM_TAGS];
  logic          tag_we;
  logic [TW-1:0] tag_wa, tag_ra;
  tag_ent_t      tag_wd, tag_rd_q;

  logic [NW-1:0] cnt_mem [MAX_PEOPLE];
  logic          cnt_we;
  logic [LW-1:0] cnt_wa, cnt_ra;
  logic [NW-1:0] cnt_wd, cnt_rd_q;

  logic [NW-1:0] hist_mem [MAX_PEOPLE + 1];
  logic          hist_we;
  logic [NW-1:0] hist_wa, hist_ra, hist_wd, hist_rd_q;

  logic [NW-1:0] idx_nxt, emit_nxt;

  assign idx_nxt  = idx_q + NW'(1);
  assign emit_nxt = emit_q + NW'(1);

  // Group label memory
  always_ff @(posedge clk_i) begin
    if (lbl_we) begin
      lbl_mem[lbl_wa] <= lbl_wd;
    end
    lbl_rd_q <= lbl_mem[lbl_ra];
  end

  // Hobby tag memory: seen mark and last member
  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[tag_wa] <= tag_wd;
    end
    tag_rd_q <= tag_mem[tag_ra];
  end

  // Per-label member counts, cleared again as the histogram is built
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_rd_q <= cnt_mem[cnt_ra];
  end

  // Clusters per size, cleared again as results go out
  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    hist_rd_q <= hist_mem[hist_ra];
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    init_d      = init_q;
    idx_d       = idx_q;
    k_d         = k_q;
    emit_d      = emit_q;
    rem_d       = rem_q;
    pend_d      = 1'b0;
    out_valid_d = out_valid_q;
    person_d    = person_q;
    hobby_d     = hobby_q;
    la_d        = la_q;
    from_d      = from_q;
    to_d        = to_q;
    pidx_d      = pidx_q;
    lab_d       = lab_q;
    val_d       = val_q;
    out_d       = out_q;
    lbl_we      = 1'b0;
    lbl_wa      = '0;
    lbl_wd      = '0;
    lbl_ra      = '0;
    tag_we      = 1'b0;
    tag_wa      = '0;
    tag_wd      = '0;
    tag_ra      = '0;
    cnt_we      = 1'b0;
    cnt_wa      = '0;
    cnt_wd      = '0;
    cnt_ra      = '0;
    hist_we     = 1'b0;
    hist_wa     = '0;
    hist_wd     = '0;
    hist_ra     = '0;

    unique case (state_q)
      // Clearing pass: labels to identity, counts, histogram and tags to zero
      S_INIT: begin
        lbl_we  = (int'(init_q) < MAX_PEOPLE);
        lbl_wa  = init_q[LW-1:0];
        lbl_wd  = init_q[LW-1:0];
        cnt_we  = (int'(init_q) < MAX_PEOPLE);
        cnt_wa  = init_q[LW-1:0];
        hist_we = (int'(init_q) <= MAX_PEOPLE);
        hist_wa = init_q[NW-1:0];
        tag_we  = (int'(init_q) < NUM_TAGS);
        tag_wa  = init_q[TW-1:0];
        if (init_q == IW'(INIT_LEN - 1)) begin
          state_d = S_IDLE;
        end else begin
          init_d = init_q + IW'(1);
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          person_d = in_item_i.person;
          hobby_d  = TW'(in_item_i.hobby);
          if (in_item_i.req_type == REQ_REPORT) begin
            idx_d   = '0;
            k_d     = '0;
            state_d = S_R_LRD;
          end else if (int'(in_item_i.person) < int'(n_eff) &&
                       int'(in_item_i.hobby) < NUM_TAGS) begin
            state_d = S_M_TAG;
          end
        end
      end

      // Membership: look up the hobby
      S_M_TAG: begin
        tag_ra  = hobby_q;
        state_d = S_M_LA;
      end

      // Remember the new person; merge only with a member still in use
      S_M_LA: begin
        tag_we = 1'b1;
        tag_wa = hobby_q;
        tag_wd = '{seen: 1'b1, member: person_q};
        if (tag_rd_q.seen && int'(tag_rd_q.member) < int'(n_eff)) begin
          lbl_ra  = LW'(tag_rd_q.member);
          state_d = S_M_LB;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_M_LB: begin
        la_d    = lbl_rd_q;
        lbl_ra  = LW'(person_q);
        state_d = S_M_CMP;
      end

      // Same label: nothing to do
      S_M_CMP: begin
        if (la_q == lbl_rd_q) begin
          state_d = S_IDLE;
        end else begin
          from_d  = (la_q > lbl_rd_q) ? la_q : lbl_rd_q;
          to_d    = (la_q > lbl_rd_q) ? lbl_rd_q : la_q;
          idx_d   = '0;
          state_d = S_M_SWP;
        end
      end

      // Relabel sweep: read entry i, write back entry i-1
      S_M_SWP: begin
        lbl_ra = idx_q[LW-1:0];
        pend_d = 1'b1;
        pidx_d = idx_q[LW-1:0];
        if (pend_q && lbl_rd_q == from_q) begin
          lbl_we = 1'b1;
          lbl_wa = pidx_q;
          lbl_wd = to_q;
        end
        idx_d = idx_nxt;
        if (idx_q == NW'(MAX_PEOPLE - 1)) begin
          state_d = S_M_DRN;
        end
      end

      S_M_DRN: begin
        if (pend_q && lbl_rd_q == from_q) begin
          lbl_we = 1'b1;
          lbl_wa = pidx_q;
          lbl_wd = to_q;
        end
        state_d = S_IDLE;
      end

      // Report: count members per label
      S_R_LRD: begin
        lbl_ra  = idx_q[LW-1:0];
        state_d = S_R_CRD;
      end

      S_R_CRD: begin
        lab_d   = lbl_rd_q;
        cnt_ra  = lbl_rd_q;
        state_d = S_R_CWR;
      end

      S_R_CWR: begin
        cnt_we = 1'b1;
        cnt_wa = lab_q;
        cnt_wd = cnt_rd_q + NW'(1);
        if (idx_nxt == n_eff) begin
          idx_d   = '0;
          state_d = S_R_HRD;
        end else begin
          idx_d   = idx_nxt;
          state_d = S_R_LRD;
        end
      end

      // Histogram of cluster sizes; labels never exceed the people in use
      S_R_HRD: begin
        cnt_ra  = idx_q[LW-1:0];
        state_d = S_R_HCHK;
      end

      S_R_HCHK: begin
        val_d = cnt_rd_q;
        if (cnt_rd_q != '0) begin
          cnt_we  = 1'b1;
          cnt_wa  = idx_q[LW-1:0];
          hist_ra = cnt_rd_q;
          k_d     = k_q + NW'(1);
          state_d = S_R_HWR;
        end else if (idx_nxt == n_eff) begin
          idx_d   = n_eff;
          emit_d  = '0;
          state_d = S_R_ERD;
        end else begin
          idx_d   = idx_nxt;
          state_d = S_R_HRD;
        end
      end

      S_R_HWR: begin
        hist_we = 1'b1;
        hist_wa = val_q;
        hist_wd = hist_rd_q + NW'(1);
        if (idx_nxt == n_eff) begin
          idx_d   = n_eff;
          emit_d  = '0;
          state_d = S_R_ERD;
        end else begin
          idx_d   = idx_nxt;
          state_d = S_R_HRD;
        end
      end

      // Emit sizes from the largest down
      S_R_ERD: begin
        hist_ra = idx_q;
        state_d = S_R_ECHK;
      end

      S_R_ECHK: begin
        if (hist_rd_q == '0) begin
          idx_d   = idx_q - NW'(1);
          state_d = S_R_ERD;
        end else begin
          hist_we             = 1'b1;
          hist_wa             = idx_q;
          rem_d               = hist_rd_q;
          out_valid_d         = 1'b1;
          out_d.cluster_count = (emit_q == '0) ? COUNT_W'(k_q) : '0;
          out_d.grp_size      = COUNT_W'(idx_q);
          out_d.last          = (emit_nxt == k_q);
          state_d             = S_R_OUT;
        end
      end

      S_R_OUT: begin
        if (!out_stall_i) begin
          emit_d = emit_nxt;
          rem_d  = rem_q - NW'(1);
          if (rem_q == NW'(1)) begin
            out_valid_d = 1'b0;
            if (emit_nxt == k_q) begin
              state_d = S_IDLE;
            end else begin
              idx_d   = idx_q - NW'(1);
              state_d = S_R_ERD;
            end
          end else begin
            out_d.cluster_count = '0;
            out_d.last = ((NW+1)'(emit_nxt) + (NW+1)'(1) == (NW+1)'(k_q));
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_q      <= '0;
      idx_q       <= '0;
      k_q         <= '0;
      emit_q      <= '0;
      rem_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      idx_q       <= idx_d;
      k_q         <= k_d;
      emit_q      <= emit_d;
      rem_q       <= rem_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    person_q <= person_d;
    hobby_q  <= hobby_d;
    la_q     <= la_d;
    from_q   <= from_d;
    to_q     <= to_d;
    pidx_q   <= pidx_d;
    lab_q    <= lab_d;
    val_q    <= val_d;
    out_q    <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: design/stc_checker.sv
// Port-level checks for the shared tag cluster sizes block, bound to the top
`include "assert_macros.svh"

module stc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input stc_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input stc_pkg::out_item_t out_item_o
);
  import stc_pkg::*;

  logic take_report;

  // A report item taken at this edge
  assign take_report = in_valid_i && !in_stall_o && in_item_i.req_type == REQ_REPORT;

  // A stalled result holds
  `STC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))

  // No new item is taken while a result is shown
  `STC_ASSERT(a_busy_on_out, out_valid_o |-> in_stall_o)

  // A report keeps the block busy in the next cycle
  `STC_ASSERT(a_report_busy, take_report |=> in_stall_o)

  // Every cluster has at least one member
  `STC_ASSERT(a_size_nonzero, out_valid_o |-> out_item_o.grp_size != '0)

  // No result once reset has been seen at an edge
  `STC_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !out_valid_o)

endmodule

bind shared_tag_cluster_sizes stc_checker u_stc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

// File: sim/shared_tag_cluster_sizes_tb.sv
// Testbench for shared_tag_cluster_sizes: directed and random items checked against a predictor
module shared_tag_cluster_sizes_tb;
  import stc_pkg::*;

  localparam int PEOPLE     = MAX_PEOPLE_DEF;
  localparam int TAGS       = NUM_TAGS_DEF;
  // settle time: room for a merge item's relabel sweep, with margin
  localparam int SETTLE_CYC = 2 * (PEOPLE + 6) + 20;
  localparam int LONG_HOLD  = 3000;
  localparam int LIMIT_CYC  = 3000000;
  localparam int PRINT_MAX  = 40;

  // DUT connections
  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               in_valid   = 1'b0;
  in_item_t           in_item    = '0;
  logic               out_stall  = 1'b0;
  logic               psel       = 1'b0;
  logic               penable    = 1'b0;
  logic               pwrite     = 1'b0;
  logic [PADDR_W-1:0] paddr      = '0;
  logic [PDATA_W-1:0] pwdata     = '0;
  logic               in_stall;
  logic               out_valid;
  out_item_t          out_item;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // stimulus knobs and bookkeeping
  int  tx_idle_pct  = 0;
  int  rx_stall_pct = 0;
  logic hold_on     = 1'b0;
  event hold_ev;
  int  err_cnt      = 0;
  int  n_member     = 0;
  int  n_report     = 0;
  int  n_results    = 0;
  int  n_cfg        = 0;

  // predictor state
  logic [PERSON_W-1:0] cluster_label [PEOPLE];
  logic [PERSON_W-1:0] hobby_holder  [TAGS];
  bit                  hobby_seen    [TAGS];
  logic [COUNT_W-1:0]  people_cfg;
  out_item_t           sizes_due [$];

  shared_tag_cluster_sizes dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  // register value as the block applies it: 0 acts as 1, above PEOPLE clamps
  function automatic int people_in_use();
    if (people_cfg == 0) return 1;
    if (people_cfg > PEOPLE) return PEOPLE;
    return int'(people_cfg);
  endfunction

  // quick-find union: relabel the larger label of the pair to the smaller one
  function automatic void join_by_hobby(input int person, input int hobby);
    int n;
    logic [PERSON_W-1:0] la, lb, hi, lo;
    n = people_in_use();
    if (person >= n) return;
    if (hobby_seen[hobby] && hobby_holder[hobby] < n) begin
      la = cluster_label[hobby_holder[hobby]];
      lb = cluster_label[person];
      if (la != lb) begin
        hi = (la > lb) ? la : lb;
        lo = (la > lb) ? lb : la;
        for (int i = 0; i < PEOPLE; i++)
          if (cluster_label[i] == hi) cluster_label[i] = lo;
      end
    end
    hobby_seen[hobby]   = 1'b1;
    hobby_holder[hobby] = PERSON_W'(person);
  endfunction

  // cluster sizes of the people in use, largest first
  function automatic void tally_clusters();
    int members [PEOPLE];
    int sorted  [PEOPLE];
    int n, k, j;
    out_item_t r;
    n = people_in_use();
    k = 0;
    foreach (members[i]) members[i] = 0;
    for (int i = 0; i < n; i++) members[cluster_label[i]]++;
    for (int i = 0; i < PEOPLE; i++) begin
      if (members[i] != 0) begin
        j = k;
        while (j > 0 && sorted[j-1] < members[i]) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = members[i];
        k++;
      end
    end
    for (int i = 0; i < k; i++) begin
      r.cluster_count = (i == 0) ? COUNT_W'(k) : '0;
      r.grp_size      = COUNT_W'(sorted[i]);
      r.last          = (i == k - 1);
      sizes_due = {sizes_due, r};
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  // offer one item after idle cycles drawn one at a time; predict once taken
  task automatic send_item(input in_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (in_stall);
    if (it.req_type == REQ_REPORT) begin
      tally_clusters();
      n_report++;
    end else begin
      join_by_hobby(it.person, it.hobby);
      n_member++;
    end
  endtask

  task automatic send_member(input int p, input int h);
    in_item_t it;
    it.req_type = REQ_MEMBER;
    it.person   = PERSON_W'(p);
    it.hobby    = HOBBY_W'(h);
    send_item(it);
  endtask

  task automatic send_report();
    in_item_t it;
    it.req_type = REQ_REPORT;
    it.person   = PERSON_W'($urandom_range(63));
    it.hobby    = HOBBY_W'($urandom_range(TAGS - 1));
    send_item(it);
  endtask

  // APB write of the people-in-use register: setup then access
  task automatic write_people(input logic [COUNT_W-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_NUM_PEOPLE, 2'b00};
    pwdata  <= PDATA_W'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    people_cfg = val;
    n_cfg++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // stop offering, let every expected size arrive, then cover a trailing merge
  task automatic settle_idle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sizes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // mostly members of a small hobby window, some reports, some noise
  function automatic in_item_t random_item(input int base, input int span);
    in_item_t it;
    int r;
    r = $urandom_range(99);
    it.req_type = REQ_MEMBER;
    it.person   = PERSON_W'($urandom_range(63));
    it.hobby    = HOBBY_W'($urandom_range(TAGS - 1));
    if (r < 12) begin
      it.req_type = REQ_REPORT;
    end else if (r < 85) begin
      it.person = PERSON_W'($urandom_range(people_in_use() - 1));
      it.hobby  = HOBBY_W'((base + $urandom_range(span - 1)) % TAGS);
    end
    return it;
  endfunction

  // ---------------------------------------------------------------- receiver

  // random stall, forced high while a long hold-off runs
  always @(negedge clk_i) begin
    out_stall <= hold_on || ($urandom_range(99) < rx_stall_pct);
  end

  always begin
    @(hold_ev);
    hold_on = 1'b1;
    repeat (LONG_HOLD) @(posedge clk_i);
    hold_on = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    err_cnt++;
    if (err_cnt <= PRINT_MAX)
      $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
  endtask

  // compare each taken result with the oldest expected size
  always @(posedge clk_i) begin : check_result
    out_item_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (sizes_due.size() == 0) begin
        report_mismatch("unexpected result, size", out_item.grp_size, 0);
      end else begin
        want = sizes_due.pop_front();
        n_results++;
        if (out_item.cluster_count != want.cluster_count)
          report_mismatch("cluster_count", out_item.cluster_count, want.cluster_count);
        if (out_item.grp_size != want.grp_size)
          report_mismatch("grp_size", out_item.grp_size, want.grp_size);
        if (out_item.last != want.last)
          report_mismatch("last", out_item.last, want.last);
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // all singletons, chained merges across both ends of the fields, same cluster
  task automatic test_fresh_and_merges();
    send_report();
    send_member(0, 0);
    send_member(63, 0);
    send_member(63, TAGS - 1);
    send_member(5, TAGS - 1);
    send_member(0, TAGS - 1);
    send_report();
  endtask

  // zero acts as one person, values above the table clamp
  task automatic test_register_extremes();
    settle_idle();
    write_people(7'd0);
    send_report();
    send_member(1, 5);
    send_member(0, 5);
    send_report();
    settle_idle();
    write_people(7'd127);
    send_report();
    settle_idle();
    write_people(7'd1);
    send_member(0, TAGS - 1);
    send_report();
  endtask

  // remembered holder dropped out of use: no merge, new person takes over
  task automatic test_stale_holder();
    settle_idle();
    write_people(7'd64);
    send_member(50, 300);
    settle_idle();
    write_people(7'd10);
    send_member(3, 300);
    send_member(4, 300);
    send_member(12, 300);
    send_report();
  endtask

  task automatic test_random_phase(input int cfg, input int tx, input int rx, input int count);
    int base, span;
    settle_idle();
    write_people(COUNT_W'(cfg));
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
    base = $urandom_range(TAGS - 1);
    span = 2 * people_in_use() + 4;
    repeat (count) send_item(random_item(base, span));
  endtask

  // output held off for a long stretch while items keep coming
  task automatic test_backpressure();
    settle_idle();
    write_people(7'd64);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    -> hold_ev;
    send_report();
    repeat (8) send_member($urandom_range(63), $urandom_range(TAGS - 1));
    send_report();
    send_report();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    for (int i = 0; i < PEOPLE; i++) cluster_label[i] = PERSON_W'(i);
    foreach (hobby_seen[i]) hobby_seen[i] = 1'b0;
    people_cfg = NUM_PEOPLE_RST;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_fresh_and_merges();
    test_register_extremes();
    test_stale_holder();
    test_random_phase(64, 0, 0, 97);
    test_random_phase($urandom_range(63, 2), 88, 0, 97);
    test_random_phase(127, 0, 88, 97);
    test_random_phase($urandom_range(127, 1), 34, 34, 97);
    test_backpressure();
    settle_idle();

    $display("covered %0d membership and %0d report items, %0d cluster sizes checked",
             n_member, n_report, n_results);
    $display("register written %0d times incl. zero and clamp, with a long output hold-off",
             n_cfg);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    repeat (LIMIT_CYC) @(posedge clk_i);
    $display("timeout after %0d cycles", LIMIT_CYC);
    $display("FAIL");
    $finish;
  end

endmodule
